// ===== hw/rtl/aob_pkg.sv =====
// Shared constants for the alpha-over blend pipeline.
// No dependencies.
package aob_pkg;
  localparam int unsigned ChW = 8;
  localparam int unsigned OpW = 9;
  localparam logic [8:0] OpacityFull = 9'd256;
  localparam logic [7:0] AlphaMax = 8'd255;
  localparam int unsigned QBits = 8;
  localparam int unsigned NumW = 25;
  localparam int unsigned Latency = 12;
endpackage

// ===== hw/rtl/alpha_over_blend_top.sv =====
// Top level of the straight-alpha RGBA8 source-over blend pipeline.
// Depends on aob_pkg.
// start reaches done through v1, v2, v3, v[0] and the divide stages; throughput one word per cycle.
// Eight stages run a restoring divide, one quotient bit each, for three colors.
// busy stays low; the receiver cannot stall, so nothing ever holds.
// Reset clears all valid bits and sets opacity to 256.
module alpha_over_blend_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opacity_we,
  input  logic [8:0] opacity_wdata,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_a,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic       done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  localparam int unsigned NW = aob_pkg::NumW;
  localparam int unsigned QB = aob_pkg::QBits;

  logic [8:0] opacity;
  logic [15:0] sa_prod;
  logic [7:0] sa_in;

  logic v1;
  logic [7:0] sc1 [3];
  logic [7:0] dc1 [3];
  logic [7:0] sa1, da1;

  logic v2, byp2;
  logic [31:0] bp2;
  logic [7:0] sc2 [3];
  logic [7:0] dc2 [3];
  logic [15:0] sa255_2, w2;

  logic v3, byp3;
  logic [31:0] bp3;
  logic [23:0] ps3 [3];
  logic [23:0] pd3 [3];
  logic [15:0] den3;
  logic [16:0] al_sum;

  logic v [QB+1];
  logic byp [QB+1];
  logic [31:0] bp [QB+1];
  logic [15:0] den [QB+1];
  logic [7:0] al [QB+1];
  logic [NW-1:0] rem [QB+1][3];
  logic [7:0] q [QB+1][3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity <= aob_pkg::OpacityFull;
    end else if (opacity_we) begin
      opacity <= opacity_wdata;
    end
  end

  assign sa_prod = 16'(src_a) * 16'(opacity[7:0]);
  assign sa_in = (opacity < aob_pkg::OpacityFull) ? sa_prod[15:8] : src_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
    sc1[0] <= src_red;
    sc1[1] <= src_green;
    sc1[2] <= src_blue;
    dc1[0] <= dst_red;
    dc1[1] <= dst_green;
    dc1[2] <= dst_blue;
    sa1 <= sa_in;
    da1 <= dst_alpha;

    sc2 <= sc1;
    dc2 <= dc1;
    sa255_2 <= {sa1, 8'd0} - {8'd0, sa1};
    w2 <= 16'(da1) * 16'(aob_pkg::AlphaMax - sa1);
    if (sa1 == 8'd0) begin
      byp2 <= 1'b1;
      bp2 <= {dc1[0], dc1[1], dc1[2], da1};
    end else begin
      byp2 <= (sa1 == aob_pkg::AlphaMax) || (da1 == 8'd0);
      bp2 <= {sc1[0], sc1[1], sc1[2], sa1};
    end

    byp3 <= byp2;
    bp3 <= bp2;
    den3 <= sa255_2 + w2;
    for (int c = 0; c < 3; c++) begin
      ps3[c] <= 24'(sc2[c]) * 24'(sa255_2);
      pd3[c] <= 24'(dc2[c]) * 24'(w2);
    end
  end

  assign al_sum = {1'b0, den3} + 17'd1 + {9'd0, den3[15:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= v3;
    end
    byp[0] <= byp3;
    bp[0] <= bp3;
    den[0] <= den3;
    al[0] <= al_sum[15:8];
    for (int c = 0; c < 3; c++) begin
      rem[0][c] <= NW'(ps3[c]) + NW'(pd3[c]);
      q[0][c] <= 8'd0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [NW-1:0] dsh;
    assign dsh = NW'(den[k]) << (QB - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      byp[k+1] <= byp[k];
      bp[k+1] <= bp[k];
      den[k+1] <= den[k];
      al[k+1] <= al[k];
      for (int c = 0; c < 3; c++) begin
        if (rem[k][c] >= dsh) begin
          rem[k+1][c] <= rem[k][c] - dsh;
          q[k+1][c] <= {q[k][c][6:0], 1'b1};
        end else begin
          rem[k+1][c] <= rem[k][c];
          q[k+1][c] <= {q[k][c][6:0], 1'b0};
        end
      end
    end
  end

  assign done = v[QB];
  assign out_red = byp[QB] ? bp[QB][31:24] : q[QB][0];
  assign out_green = byp[QB] ? bp[QB][23:16] : q[QB][1];
  assign out_blue = byp[QB] ? bp[QB][15:8] : q[QB][2];
  assign out_alpha = byp[QB] ? bp[QB][7:0] : al[QB];
endmodule

// ===== hw/rtl/aob_check.sv =====
// Port-level checks for the alpha-over blend pipeline, bound to the top level.
// Depends on aob_pkg and alpha_over_blend_top.
module aob_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] src_red,
  input logic [7:0] src_a,
  input logic [7:0] dst_red,
  input logic [7:0] dst_alpha,
  input logic       done,
  input logic [7:0] out_red,
  input logic [7:0] out_alpha
);
  localparam int unsigned L = aob_pkg::Latency;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, L))
    else $error("done without a word started");

  a_clear_src: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && src_a == 8'd0, L) |->
      out_red == $past(dst_red, L) && out_alpha == $past(dst_alpha, L))
    else $error("transparent source did not pass destination");

  a_empty_dst: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && dst_alpha == 8'd0, L) |->
      out_alpha <= $past(src_a, L) &&
      (out_red == $past(src_red, L) || out_red == $past(dst_red, L)))
    else $error("empty destination did not pass source");
endmodule

bind alpha_over_blend_top aob_check u_aob_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .src_red(src_red), .src_a(src_a), .dst_red(dst_red),
  .dst_alpha(dst_alpha), .done(done), .out_red(out_red), .out_alpha(out_alpha)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the straight-alpha RGBA8 source-over blend pipeline.
// Depends on aob_pkg and alpha_over_blend_top; predicts each blended pixel in-line.
`timescale 1ns / 100ps

module tb_top;
  typedef struct packed {
    logic [7:0] sr, sg, sb, sa, dr, dg, db, da;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } pix_out_t;

  localparam logic [1:0] KindPixel = 2'd0;
  localparam logic [1:0] KindOpacity = 2'd1;
  localparam logic [1:0] KindDrain = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] opacity;
    pix_in_t    px;
  } job_t;

  logic clk = 0, rst = 1, start = 0, opacity_we = 0;
  logic [8:0] opacity_wdata = '0;
  logic [7:0] src_red = 0, src_green = 0, src_blue = 0, src_a = 0;
  logic [7:0] dst_red = 0, dst_green = 0, dst_blue = 0, dst_alpha = 0;
  logic busy, done;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  job_t       job_q[$];
  pix_out_t   blend_q[$];
  logic [8:0] model_opacity = aob_pkg::OpacityFull;
  int         errors = 0;
  int         cycles = 0;
  int         hold = 0;
  bit         no_idle = 0;
  bit         stim_done = 0;

  alpha_over_blend_top DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pix_out_t blend_over(pix_in_t p, logic [8:0] opac);
    pix_out_t o;
    int unsigned a, w, den;
    a = p.sa;
    if (opac < aob_pkg::OpacityFull) a = (a * opac) >> 8;
    if (a == 0) begin
      o = {p.dr, p.dg, p.db, p.da};
    end else if (a == 255 || p.da == 0) begin
      o = {p.sr, p.sg, p.sb, 8'(a)};
    end else begin
      w = p.da * (255 - a);
      den = a * 255 + w;
      o.r = 8'((p.sr * a * 255 + p.dr * w) / den);
      o.g = 8'((p.sg * a * 255 + p.dg * w) / den);
      o.b = 8'((p.sb * a * 255 + p.db * w) / den);
      o.a = 8'(den / 255);
    end
    return o;
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: p.sa = 0;
      1: p.sa = 255;
      2: p.da = 0;
      3: p.da = 255;
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pixel(pix_in_t p);
    job_q.push_back({KindPixel, 9'd0, p});
  endtask

  task automatic add_opacity(logic [8:0] v);
    job_q.push_back({KindDrain, 9'd0, 64'd0});
    job_q.push_back({KindOpacity, v, 64'd0});
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      start <= 0;
      opacity_we <= 0;
    end else begin
      opacity_we <= 0;
      if (start && !busy) begin
        blend_q.push_back(blend_over({src_red, src_green, src_blue, src_a,
                                      dst_red, dst_green, dst_blue, dst_alpha},
                                     model_opacity));
      end
      if (start && busy) begin
        // hold
      end else if (hold > 0) begin
        start <= 0;
        hold <= hold - 1;
      end else if (job_q.size() == 0) begin
        start <= 0;
        stim_done <= 1;
      end else if (job_q[0].kind == KindDrain) begin
        start <= 0;
        if (blend_q.size() == 0 && !(start && !busy)) begin
          void'(job_q.pop_front());
          hold <= aob_pkg::Latency + 4;
        end
      end else if (job_q[0].kind == KindOpacity) begin
        start <= 0;
        opacity_we <= 1;
        opacity_wdata <= job_q[0].opacity;
        model_opacity <= job_q[0].opacity;
        void'(job_q.pop_front());
      end else if (!no_idle && $urandom_range(0, 99) < 26) begin
        start <= 0;
      end else begin
        start <= 1;
        {src_red, src_green, src_blue, src_a,
         dst_red, dst_green, dst_blue, dst_alpha} <= job_q[0].px;
        void'(job_q.pop_front());
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pix_out_t exp_px;
    if (!rst && done) begin
      if (blend_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time,
                 {out_red, out_green, out_blue, out_alpha});
        errors <= errors + 1;
      end else begin
        exp_px = blend_q.pop_front();
        if (exp_px != {out_red, out_green, out_blue, out_alpha}) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_px,
                   {out_red, out_green, out_blue, out_alpha});
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    int n;
    logic [8:0] op_set[6];
    op_set = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd511, 9'd256};
    repeat (12) @(posedge clk);
    rst <= 0;
    add_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    add_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    add_pixel({8'd10, 8'd20, 8'd30, 8'd128, 8'd200, 8'd100, 8'd50, 8'd0});
    add_pixel({8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255});
    add_pixel({8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1});
    add_pixel({8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1});
    add_pixel({8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1});
    add_pixel({8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA});
    add_pixel({8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55});
    add_opacity(9'd0);
    add_pixel({8'd1, 8'd2, 8'd3, 8'd255, 8'd4, 8'd5, 8'd6, 8'd7});
    add_opacity(9'd511);
    add_pixel({8'd1, 8'd2, 8'd3, 8'd200, 8'd4, 8'd5, 8'd6, 8'd7});
    add_opacity(9'd1);
    add_pixel({8'd9, 8'd8, 8'd7, 8'd255, 8'd6, 8'd5, 8'd4, 8'd3});
    add_opacity(9'd255);
    add_pixel({8'd9, 8'd8, 8'd7, 8'd255, 8'd6, 8'd5, 8'd4, 8'd3});
    for (int ph = 0; ph < 6; ph++) begin
      add_opacity(ph == 2 ? 9'($urandom) : op_set[ph]);
      n = (ph == 5) ? 400 : 90;
      for (int i = 0; i < n; i++) add_pixel(rand_pixel());
    end
    wait (job_q.size() < 300);
    no_idle = 1;
    wait (job_q.size() < 150);
    no_idle = 0;
    wait (stim_done);
    wait (blend_q.size() == 0);
    repeat (aob_pkg::Latency + 8) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= 200000);
    $display("FAIL");
    $finish;
  end
endmodule
